>>> hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// quaternion to euler package
// shared constants and helpers for the quaternion to euler angle converter
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF  = 16;

    localparam logic [15:0] POLE_THR_RESET = 16'd32735;

    // angle unit 2^-30 rad, 36-bit signed angle accumulators
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam logic [1:0] POLE_NONE  = 2'd0;
    localparam logic [1:0] POLE_NORTH = 2'd1;
    localparam logic [1:0] POLE_SOUTH = 2'd2;

    localparam logic [0:0] REG_POLE_THR = 1'b0;

    function automatic logic signed [35:0] atan_step(input int i);
        logic signed [35:0] r;
        r = '0;
        case (i)
            0: r = 36'sd843314857;
            1: r = 36'sd497837829;
            2: r = 36'sd263043837;
            3: r = 36'sd133525159;
            4: r = 36'sd67021687;
            5: r = 36'sd33543516;
            6: r = 36'sd16775851;
            7: r = 36'sd8388437;
            8: r = 36'sd4194283;
            9: r = 36'sd2097149;
            default: begin
                if (i <= 30) begin
                    r = 36'sd1 <<< (30 - i);
                end
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte cordic
// pipelined vectoring cordic atan2 with quadrant fold, one stage per iteration
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [35:0]  i_y,
    input  logic signed [35:0]  i_x,
    output logic signed [35:0]  o_z
);
    import qte_pkg::*;

    // x can grow to about 1.65 * 2^34 after folding, so 38 bits
    localparam int W = 38;

    logic signed [W-1:0]  r_x [0:CORDIC_STAGES];
    logic signed [W-1:0]  r_y [0:CORDIC_STAGES];
    logic signed [35:0]   r_z [0:CORDIC_STAGES];

    logic signed [W-1:0]  n_x0;
    logic signed [W-1:0]  n_y0;
    logic signed [35:0]   n_z0;

    always_comb begin
        n_x0 = W'(i_x);
        n_y0 = W'(i_y);
        n_z0 = '0;
        if (i_x < 0) begin
            n_z0 = (i_y >= 0) ? PI_Q30 : -PI_Q30;
            n_x0 = -W'(i_x);
            n_y0 = -W'(i_y);
        end
        if (i_x == 0 && i_y == 0) begin
            n_x0 = '0;
            n_y0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    // zero vector stays zero through every stage, so z stays zero
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam int SH = (g > 37) ? 37 : g;
        logic signed [W-1:0] n_x;
        logic signed [W-1:0] n_y;
        logic signed [35:0]  n_z;
        logic                zero;
        always_comb begin
            zero = (r_x[g] == 0) && (r_y[g] == 0) && (r_z[g] == 0);
            if (r_y[g] >= 0) begin
                n_x = r_x[g] + (r_y[g] >>> SH);
                n_y = r_y[g] - (r_x[g] >>> SH);
                n_z = r_z[g] + (zero ? 36'sd0 : atan_step(g));
            end else begin
                n_x = r_x[g] - (r_y[g] >>> SH);
                n_y = r_y[g] + (r_x[g] >>> SH);
                n_z = r_z[g] - atan_step(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1] <= n_x;
                r_y[g+1] <= n_y;
                r_z[g+1] <= n_z;
            end
        end
    end

    assign o_z = r_z[CORDIC_STAGES];

endmodule

>>> hw/rtl/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte isqrt
// pipelined restoring integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [60:0]   i_n,
    output logic [30:0]   o_r
);
    localparam int NB = 31;

    logic [61:0] r_n [0:NB];
    logic [61:0] r_r [0:NB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= {1'b0, i_n};
            r_r[0] <= '0;
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_bit
        localparam logic [61:0] B = 62'd1 << (2 * (NB - 1 - g));
        logic [61:0] n_n;
        logic [61:0] n_r;
        always_comb begin
            if (r_n[g] >= r_r[g] + B) begin
                n_n = r_n[g] - (r_r[g] + B);
                n_r = (r_r[g] >> 1) + B;
            end else begin
                n_n = r_n[g];
                n_r = r_r[g] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g+1] <= n_n;
                r_r[g+1] <= n_r;
            end
        end
    end

    assign o_r = r_r[NB][30:0];

endmodule

>>> hw/rtl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion to euler
// converts a q1.15 quaternion into pitch, yaw and roll in q4.12 radians
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready with quat_w, quat_x, quat_y, quat_z
// output channel: o_valid / i_ready with pitch, yaw, roll and pole case
// config: apb port, register 0 at address 0 is the 16-bit pole threshold
// one beat enters per cycle while o_ready is high; o_valid rises once the
// beat has passed six front-end stages, the 32-register square root, the
// cordic with its input register and the output register
// the whole pipeline advances only while the output register is free or
// being taken, so a stalled receiver holds every beat in place
// reset clears all valid bits and loads the threshold reset value
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int SAMPLE_WIDTH  = qte_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quat_w,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quat_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quat_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_quat_z,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_pitch_angle,
    output logic signed [SAMPLE_WIDTH-1:0] o_yaw_angle,
    output logic signed [SAMPLE_WIDTH-1:0] o_roll_angle,
    output logic [1:0]                o_pole_case
);
    import qte_pkg::*;

    localparam int PRE   = 8;
    localparam int LAT   = PRE + 31 + CORDIC_STAGES;
    localparam int OFRAC = SAMPLE_WIDTH - 4;
    localparam int SH    = 30 - OFRAC;

    logic [15:0] r_thr;
    logic        adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= POLE_THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_POLE_THR) begin
            r_thr <= pwdata[15:0];
        end
    end
    assign prdata = (paddr[2] == REG_POLE_THR) ? {16'd0, r_thr} : 32'd0;

    // stage 0: reduce to q1.15
    function automatic logic signed [15:0] to_q15(input logic signed [SAMPLE_WIDTH-1:0] v);
        logic signed [47:0] t;
        t = 48'(v);
        if (SAMPLE_WIDTH >= 16) begin
            t = t >>> (SAMPLE_WIDTH - 16);
        end else begin
            t = t <<< ((16 - SAMPLE_WIDTH) & 15);
        end
        return t[15:0];
    endfunction

    logic [LAT:0] r_vld;
    logic signed [15:0] r_w, r_x, r_y, r_z;

    // stage 1: products
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xw, r_yz, r_wy, r_zx, r_wz, r_xy;
    logic signed [15:0] r_x1, r_y1;
    // stage 2: sums
    logic signed [34:0] r_unit, r_test, r_s2, r_yn, r_yd, r_rn, r_rd;
    logic signed [15:0] r_x2, r_y2;
    // stage 3: threshold compare products
    logic signed [51:0] r_lhs, r_rhs;
    logic signed [34:0] r3_s, r3_yn, r3_yd, r3_rn, r3_rd;
    logic signed [15:0] r3_x, r3_y;
    // stage 4: pole decision, asin clamp
    logic [1:0]         r4_pc;
    logic signed [35:0] r4_s, r4_yn, r4_yd, r4_rn, r4_rd;
    // stage 5: one minus s squared
    logic [60:0]        r5_sq;
    logic [1:0]         r5_pc;
    logic signed [35:0] r5_s, r5_yn, r5_yd, r5_rn, r5_rd;

    // pole decision and yaw operand select for stage 4
    logic [1:0] pc3;
    always_comb begin
        if (r_lhs > r_rhs) begin
            pc3 = POLE_NORTH;
        end else if (r_lhs < -r_rhs) begin
            pc3 = POLE_SOUTH;
        end else begin
            pc3 = POLE_NONE;
        end
    end

    logic signed [35:0] n_yn4, n_yd4;
    always_comb begin
        n_yn4 = 36'(r3_yn);
        n_yd4 = 36'(r3_yd);
        if (pc3 != POLE_NONE) begin
            // pole: yaw path computes atan2(y, x) with both operands scaled by 2^15
            n_yn4 = 36'(r3_y) <<< 15;
            n_yd4 = 36'(r3_x) <<< 15;
        end
    end

    logic signed [63:0] sq4;
    assign sq4 = $signed(r4_s[31:0]) * $signed(r4_s[31:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w <= to_q15(i_quat_w);
            r_x <= to_q15(i_quat_x);
            r_y <= to_q15(i_quat_y);
            r_z <= to_q15(i_quat_z);
            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xw <= r_x * r_w;
            r_yz <= r_y * r_z;
            r_wy <= r_w * r_y;
            r_zx <= r_z * r_x;
            r_wz <= r_w * r_z;
            r_xy <= r_x * r_y;
            r_x1 <= r_x;
            r_y1 <= r_y;
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r3_x <= r_x2;
            r3_y <= r_y2;
            r_unit <= 35'(r_ww) + 35'(r_xx) + 35'(r_yy) + 35'(r_zz);
            r_test <= 35'(r_xw) - 35'(r_yz);
            r_s2   <= (35'(r_xw) - 35'(r_yz)) <<< 1;
            r_yn   <= (35'(r_wy) + 35'(r_zx)) <<< 1;
            r_yd   <= 35'sd1073741824 - ((35'(r_xx) + 35'(r_yy)) <<< 1);
            r_rn   <= (35'(r_wz) + 35'(r_xy)) <<< 1;
            r_rd   <= 35'sd1073741824 - ((35'(r_zz) + 35'(r_xx)) <<< 1);
            r_lhs  <= 52'(r_test) <<< 16;
            r_rhs  <= 52'(r_unit) * $signed({1'b0, r_thr});
            r3_s <= r_s2; r3_yn <= r_yn; r3_yd <= r_yd; r3_rn <= r_rn; r3_rd <= r_rd;
            r4_pc <= pc3;
            if (r3_s > 35'sd1073741824) begin
                r4_s <= 36'sd1073741824;
            end else if (r3_s < -35'sd1073741824) begin
                r4_s <= -36'sd1073741824;
            end else begin
                r4_s <= 36'(r3_s);
            end
            r4_yn <= n_yn4; r4_yd <= n_yd4;
            r4_rn <= 36'(r3_rn); r4_rd <= 36'(r3_rd);
            r5_sq <= 61'd1152921504606846976 - sq4[60:0];
            r5_pc <= r4_pc;
            r5_s <= r4_s; r5_yn <= r4_yn; r5_yd <= r4_yd; r5_rn <= r4_rn; r5_rd <= r4_rd;
        end
    end

    // delay line matching the square root latency
    localparam int D = 31;
    logic [1:0]         r_dpc [0:D];
    logic signed [35:0] r_ds  [0:D];
    logic signed [35:0] r_dyn [0:D];
    logic signed [35:0] r_dyd [0:D];
    logic signed [35:0] r_drn [0:D];
    logic signed [35:0] r_drd [0:D];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dpc[0] <= r5_pc;
            r_ds[0]  <= r5_s;
            r_dyn[0] <= r5_yn;
            r_dyd[0] <= r5_yd;
            r_drn[0] <= r5_rn;
            r_drd[0] <= r5_rd;
        end
    end

    for (genvar g = 0; g < D; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dpc[g+1] <= r_dpc[g];
                r_ds[g+1]  <= r_ds[g];
                r_dyn[g+1] <= r_dyn[g];
                r_dyd[g+1] <= r_dyd[g];
                r_drn[g+1] <= r_drn[g];
                r_drd[g+1] <= r_drd[g];
            end
        end
    end

    logic [30:0] sq_root;
    qte_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_n   (r5_sq),
        .o_r   (sq_root)
    );

    // cordic inputs at the end of the delay line, in step with the square root
    logic signed [35:0] z_p, z_y, z_r;
    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cp (
        .i_clk (i_clk), .i_en (adv),
        .i_y (r_ds[D]), .i_x (36'(sq_root)), .o_z (z_p)
    );
    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cy (
        .i_clk (i_clk), .i_en (adv),
        .i_y (r_dyn[D]), .i_x (r_dyd[D]), .o_z (z_y)
    );
    qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cr (
        .i_clk (i_clk), .i_en (adv),
        .i_y (r_drn[D]), .i_x (r_drd[D]), .o_z (z_r)
    );

    logic [1:0] r_cpc [0:CORDIC_STAGES];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cpc[0] <= r_dpc[D];
        end
    end
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cpc
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cpc[g+1] <= r_cpc[g];
            end
        end
    end

    function automatic logic [SAMPLE_WIDTH-1:0] to_out(input logic signed [37:0] q);
        logic signed [37:0] r;
        logic signed [37:0] hi;
        r  = (q + (38'sd1 <<< (SH - 1))) >>> SH;
        hi = (38'sd1 <<< (SAMPLE_WIDTH - 1)) - 38'sd1;
        if (r > hi) begin
            r = hi;
        end
        if (r < -hi - 38'sd1) begin
            r = -hi - 38'sd1;
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    logic [1:0]         pc_o;
    logic signed [37:0] yaw_q;
    always_comb begin
        pc_o  = r_cpc[CORDIC_STAGES];
        yaw_q = 38'(z_y);
        if (pc_o == POLE_NORTH) begin
            yaw_q = 38'(z_y) <<< 1;
        end else if (pc_o == POLE_SOUTH) begin
            yaw_q = -(38'(z_y) <<< 1);
        end
    end

    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_yaw_angle <= to_out(yaw_q);
            o_pole_case <= pc_o;
            case (pc_o)
                POLE_NORTH: begin
                    o_pitch_angle <= to_out(38'(HALF_PI_Q30));
                    o_roll_angle  <= '0;
                end
                POLE_SOUTH: begin
                    o_pitch_angle <= to_out(-38'(HALF_PI_Q30));
                    o_roll_angle  <= '0;
                end
                default: begin
                    o_pitch_angle <= to_out(38'(z_p));
                    o_roll_angle  <= to_out(38'(z_r));
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_pole_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case != POLE_NONE |-> o_roll_angle == 0)
        else $error("roll not zero at pole");
    a_pole_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pole_case != 2'd3)
        else $error("bad pole code");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_yaw_angle))
        else $error("output lost under stall");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion to euler testbench
// drives quaternions through the converter under varying threshold settings
// and random idling on both channels; a bit-exact angle predictor fills a
// queue that every output beat is checked against in order
// ----------------------------------------------------------------------------
module tb;
    import qte_pkg::*;

    localparam int LATENCY   = 8 + 31 + CORDIC_STAGES_DEF;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 780;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic [1:0]         pole;
    } t_angles;

    // ------------------------------------------------------------------------
    // angle predictor
    // ------------------------------------------------------------------------
    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan2_q30(longint y, longint x);
        longint ang, dx, dy, stepv;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            ang = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            stepv = longint'(atan_step(i));
            if (y >= 0) begin
                x += dx; y -= dy; ang += stepv;
            end else begin
                x -= dx; y += dy; ang -= stepv;
            end
        end
        return ang;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [15:0] to_q412(longint q30);
        longint r;
        r = shr(q30 + (64'sd1 << 17), 18);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_angles predict_angles(logic signed [15:0] qw,
            logic signed [15:0] qx, logic signed [15:0] qy,
            logic signed [15:0] qz, logic [15:0] thr);
        t_angles a;
        longint w, x, y, z, sqx, sqy, sqz, unit_sq, lhs, rhs, t, s, c;
        w = qw; x = qx; y = qy; z = qz;
        sqx = x * x; sqy = y * y; sqz = z * z;
        unit_sq = w * w + sqx + sqy + sqz;
        lhs = (x * w - y * z) * 65536;
        rhs = longint'(thr) * unit_sq;
        if (lhs > rhs || lhs < -rhs) begin
            t = atan2_q30(y * 32768, x * 32768) * 2;
            a.pitch = to_q412(lhs > rhs ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30));
            a.yaw   = to_q412(lhs > rhs ? t : -t);
            a.roll  = '0;
            a.pole  = lhs > rhs ? POLE_NORTH : POLE_SOUTH;
        end else begin
            s = 2 * (w * x - z * y);
            if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
            if (s < -(64'sd1 << 30)) s = -(64'sd1 << 30);
            c = isqrt((64'd1 << 60) - s * s);
            a.pitch = to_q412(atan2_q30(s, c));
            a.yaw   = to_q412(atan2_q30(2 * (w * y + z * x), (64'sd1 << 30) - 2 * (sqx + sqy)));
            a.roll  = to_q412(atan2_q30(2 * (w * z + x * y), (64'sd1 << 30) - 2 * (sqz + sqx)));
            a.pole  = POLE_NONE;
        end
        return a;
    endfunction

    // ------------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------------
    class t_angle_board;
        t_angles pending[$];
        int      errors;
        logic [15:0] thr;

        function void note_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                logic signed [15:0] qy, logic signed [15:0] qz);
            pending.insert(pending.size(), predict_angles(qw, qx, qy, qz, thr));
        endfunction

        function void check_angles(t_angles got);
            t_angles exp_a;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat %h", $realtime, got);
                errors++;
                return;
            end
            exp_a = pending.pop_front();
            if (got.pitch !== exp_a.pitch) begin
                $display("%0t: pitch exp %0d got %0d", $realtime, exp_a.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== exp_a.yaw) begin
                $display("%0t: yaw exp %0d got %0d", $realtime, exp_a.yaw, got.yaw);
                errors++;
            end
            if (got.roll !== exp_a.roll) begin
                $display("%0t: roll exp %0d got %0d", $realtime, exp_a.roll, got.roll);
                errors++;
            end
            if (got.pole !== exp_a.pole) begin
                $display("%0t: pole exp %0d got %0d", $realtime, exp_a.pole, got.pole);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic i_valid, o_ready, o_valid, i_ready;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic signed [15:0] o_pitch_angle, o_yaw_angle, o_roll_angle;
    logic [1:0] o_pole_case;

    quaternion_to_euler i_dut (.*);

    t_angle_board board;
    int send_idle_pct, recv_idle_pct;
    int hold_reqs, hold_seen;
    int hold_off;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver side and checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_angles({o_pitch_angle, o_yaw_angle, o_roll_angle, o_pole_case});
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_off  <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_off  <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted beat, outside reset and hold-off
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || hold_off > 0) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_thr(logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_POLE_THR, 2'b00};
        pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.thr = value;
    endtask

    task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
            logic signed [15:0] qy, logic signed [15:0] qz);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_quat_w <= qw; i_quat_x <= qx; i_quat_y <= qy; i_quat_z <= qz;
        do @(posedge i_clk); while (!o_ready);
        board.note_quat(qw, qx, qy, qz);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mag);
        return $signed(16'($urandom_range(2 * mag) - mag));
    endfunction

    // random quaternion: half with components from -23170 to 23170, some near poles, some noise
    task automatic send_random;
        int kind;
        int sc;
        logic signed [15:0] a, b;
        kind = $urandom_range(9);
        if (kind < 5) begin
            sc = 23170;
            send_quat(rand_comp(sc), rand_comp(sc), rand_comp(sc), rand_comp(sc));
        end else if (kind < 8) begin
            a = rand_comp(23170);
            b = rand_comp(800);
            if (kind == 7) send_quat(a, -a + b, rand_comp(23170), rand_comp(600));
            else send_quat(a, a + b, rand_comp(600), rand_comp(23170));
        end else begin
            send_quat($signed(16'($urandom)), $signed(16'($urandom)),
                      $signed(16'($urandom)), $signed(16'($urandom)));
        end
    endtask

    initial begin
        board = new();
        board.thr = POLE_THR_RESET;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_quat_w = '0; i_quat_x = '0; i_quat_y = '0; i_quat_z = '0;
        send_idle_pct = 0; recv_idle_pct = 0; hold_reqs = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd23170, -16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd23170, 16'sd23170, 16'sd100, -16'sd50);
        send_quat(16'sd23170, -16'sd23170, -16'sd100, 16'sd50);
        send_quat(16'sd23170, -16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd0, -16'sd20000, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sh7fff, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sh8000);
        send_quat(16'sh7fff, 16'sh7fff, 16'sd0, 16'sd0);
        send_quat(16'sh5555, -16'sh2aab, 16'sh1234, -16'sh4321);
        drain();
        write_thr(16'd0);
        send_quat(16'sd100, 16'sd100, 16'sd0, 16'sd0);
        send_quat(16'sd100, -16'sd100, 16'sd0, 16'sd0);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        drain();
        write_thr(16'hffff);
        send_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        drain();
        write_thr(POLE_THR_RESET);

        // long receiver hold-off while items keep coming
        hold_reqs = hold_reqs + 1;
        repeat (150) send_random();
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 83 : 0;
            recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 22 : 0;
            write_thr(ph == 0 ? 16'd32735 : ph == 1 ? 16'($urandom_range(40000, 28000))
                              : 16'd30000);
            repeat (N_RANDOM / 3) send_random();
            drain();
        end

        if (board.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
